// ===== rtl/time_triggered_task_table_assert.svh =====
// Assertion macros shared by the task table RTL.
`ifndef TIME_TRIGGERED_TASK_TABLE_ASSERT_SVH
`define TIME_TRIGGERED_TASK_TABLE_ASSERT_SVH
`ifndef SYNTH
// Property must hold on every clock edge outside reset.
`define TTT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition must never be true outside reset.
`define TTT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TTT_ASSERT(lbl, prop, msg)
`define TTT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== rtl/tttt_pkg.sv =====
// Types and constants of the time triggered task table.
package tttt_pkg;

    localparam int SLOT_COUNT_DEF = 8;
    localparam int MAX_RUNS       = 8;
    localparam int RUN_W          = 4;
    localparam logic [7:0] PEND_MAX = 8'hFF;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_DEL  = 2'd1,
        OP_TICK = 2'd2,
        OP_DISP = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_ADDED   = 3'd0,
        ST_FULL    = 3'd1,
        ST_DELETED = 3'd2,
        ST_TICKED  = 3'd3,
        ST_RUN     = 3'd4,
        ST_NONE    = 3'd5
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_WALK = 1'b1
    } state_t;

    typedef struct packed {
        op_t         opcode;
        logic [15:0] task_number;
        logic [15:0] start_delay;
        logic [15:0] repeat_period;
        logic [7:0]  slot_to_delete;
    } in_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  slot;
        logic [15:0] run_task_number;
        logic        last;
    } out_t;

    // one slot as kept in the slot memory
    typedef struct packed {
        logic [15:0] task_number;
        logic [15:0] delay;
        logic [15:0] period;
        logic [7:0]  pending;
    } entry_t;

endpackage

// ===== rtl/tttt_mem.sv =====
// Slot memory: one write port, one read port, registered read data.
module tttt_mem
    import tttt_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  entry_t           wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data
);

    entry_t entries_reg [SLOT_COUNT];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entries_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= entries_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/tttt_find.sv =====
// Lowest free slot search over the used marks.
module tttt_find
    import tttt_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
)
(
    input  logic [SLOT_COUNT-1:0] used,
    output logic                  found,
    output logic [IDX_W-1:0]      idx
);

    always_comb
    begin
        found = 1'b0;
        idx   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!used[i])
            begin
                found = 1'b1;
                idx   = IDX_W'(i);
            end
        end
    end

endmodule

// ===== rtl/time_triggered_task_table.sv =====
// Top level of the time triggered task table.
//
//   channel  | ports                        | transfer
//   ---------+------------------------------+--------------------------------
//   command  | start, busy, cmd (in_t)      | start high while busy low
//   result   | result_valid, result (out_t) | one cycle strobe, always taken
//
// Add and delete: one result, the cycle after the command is taken; busy
// stays low, so a new command may follow at once.
// Tick and dispatch: the slot memory is walked one slot per cycle (read,
// then modify and write back in the next cycle); busy is high for the
// whole walk. The single read port of the slot memory sets that rate.
// Dispatch run results come out during the walk, each held back one step
// so the final one can carry last.
// Reset clears the used marks and control state; slot memory contents are
// only acted on for used slots, so they need no clearing.
// The receiver cannot stall: every result strobe is a completed transaction.
module time_triggered_task_table
    import tttt_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  in_t  cmd,
    output logic result_valid,
    output out_t result
);

`include "time_triggered_task_table_assert.svh"

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(SLOT_COUNT);
    localparam logic [7:0]       SLOT_LIM = 8'(SLOT_COUNT);
    localparam logic [RUN_W-1:0] RUN_LIM  = RUN_W'(MAX_RUNS);

    // control state
    state_t                state_reg, state_next;
    op_t                   op_reg, op_next;
    logic [CNT_W-1:0]      rd_idx_reg, rd_idx_next;    // next slot to read
    logic                  p_vld_reg, p_vld_next;      // read data stage valid
    logic [IDX_W-1:0]      p_idx_reg, p_idx_next;      // slot in read data stage
    logic [RUN_W-1:0]      run_cnt_reg, run_cnt_next;  // runs found this dispatch
    logic                  hold_vld_reg, hold_vld_next;
    logic [SLOT_COUNT-1:0] used_reg, used_next;
    logic                  out_vld_reg, out_vld_next;

    // payload
    out_t hold_reg, hold_next;
    out_t out_reg, out_next;

    // memory ports
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    entry_t           rd_data;

    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic             accept;
    logic             walk_done;

    tttt_mem #(.SLOT_COUNT(SLOT_COUNT)) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tttt_find #(.SLOT_COUNT(SLOT_COUNT)) u_find (
        .used  (used_reg),
        .found (free_found),
        .idx   (free_idx)
    );

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    // walk ends once every slot has been read and the last one written back
    assign walk_done = (state_reg == S_WALK) && (rd_idx_reg == CNT_END) && !p_vld_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd.opcode == OP_TICK || cmd.opcode == OP_DISP))
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (walk_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        entry_t ent;

        op_next       = op_reg;
        rd_idx_next   = rd_idx_reg;
        p_vld_next    = 1'b0;
        p_idx_next    = p_idx_reg;
        run_cnt_next  = run_cnt_reg;
        hold_vld_next = hold_vld_reg;
        hold_next     = hold_reg;
        used_next     = used_reg;
        out_vld_next  = 1'b0;
        out_next      = out_reg;
        wr_en         = 1'b0;
        wr_addr       = p_idx_reg;
        wr_data       = rd_data;
        rd_en         = 1'b0;
        rd_addr       = rd_idx_reg[IDX_W-1:0];
        ent           = rd_data;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next = cmd.opcode;
                    case (cmd.opcode)
                        OP_ADD:
                        begin
                            out_vld_next = 1'b1;
                            if (free_found)
                            begin
                                wr_en               = 1'b1;
                                wr_addr             = free_idx;
                                wr_data.task_number = cmd.task_number;
                                wr_data.delay       = cmd.start_delay;
                                wr_data.period      = cmd.repeat_period;
                                wr_data.pending     = 8'd0;
                                used_next[free_idx] = 1'b1;
                                out_next = '{ST_ADDED, 8'(free_idx), 16'd0, 1'b1};
                            end
                            else
                            begin
                                out_next = '{ST_FULL, 8'd0, 16'd0, 1'b1};
                            end
                        end
                        OP_DEL:
                        begin
                            out_vld_next = 1'b1;
                            if (cmd.slot_to_delete < SLOT_LIM)
                            begin
                                used_next[cmd.slot_to_delete[IDX_W-1:0]] = 1'b0;
                            end
                            out_next = '{ST_DELETED, cmd.slot_to_delete, 16'd0, 1'b1};
                        end
                        OP_TICK, OP_DISP:
                        begin
                            rd_idx_next   = '0;
                            run_cnt_next  = '0;
                            hold_vld_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                // read stage
                if (rd_idx_reg != CNT_END)
                begin
                    rd_en       = 1'b1;
                    rd_idx_next = rd_idx_reg + 1'b1;
                    p_vld_next  = 1'b1;
                    p_idx_next  = rd_idx_reg[IDX_W-1:0];
                end

                // modify and write back stage
                if (p_vld_reg && used_reg[p_idx_reg])
                begin
                    if (op_reg == OP_TICK)
                    begin
                        if (rd_data.delay == 16'd0)
                        begin
                            if (rd_data.pending != PEND_MAX)
                            begin
                                ent.pending = rd_data.pending + 8'd1;
                            end
                            if (rd_data.period != 16'd0)
                            begin
                                ent.delay = rd_data.period;
                            end
                        end
                        else
                        begin
                            ent.delay = rd_data.delay - 16'd1;
                        end
                        wr_en   = 1'b1;
                        wr_data = ent;
                    end
                    else if (rd_data.pending != 8'd0 && run_cnt_reg != RUN_LIM)
                    begin
                        ent.pending  = rd_data.pending - 8'd1;
                        wr_en        = 1'b1;
                        wr_data      = ent;
                        run_cnt_next = run_cnt_reg + 1'b1;
                        if (rd_data.period == 16'd0)
                        begin
                            used_next[p_idx_reg] = 1'b0;
                        end
                        // earlier run is now known not to be the final one
                        if (hold_vld_reg)
                        begin
                            out_vld_next = 1'b1;
                            out_next     = hold_reg;
                        end
                        hold_next     = '{ST_RUN, 8'(p_idx_reg), rd_data.task_number, 1'b0};
                        hold_vld_next = 1'b1;
                    end
                end

                if (walk_done)
                begin
                    out_vld_next = 1'b1;
                    if (op_reg == OP_TICK)
                    begin
                        out_next = '{ST_TICKED, 8'd0, 16'd0, 1'b1};
                    end
                    else if (hold_vld_reg)
                    begin
                        out_next      = hold_reg;
                        out_next.last = 1'b1;
                    end
                    else
                    begin
                        out_next = '{ST_NONE, 8'd0, 16'd0, 1'b1};
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            op_reg       <= OP_ADD;
            rd_idx_reg   <= '0;
            p_vld_reg    <= 1'b0;
            p_idx_reg    <= '0;
            run_cnt_reg  <= '0;
            hold_vld_reg <= 1'b0;
            used_reg     <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            rd_idx_reg   <= rd_idx_next;
            p_vld_reg    <= p_vld_next;
            p_idx_reg    <= p_idx_next;
            run_cnt_reg  <= run_cnt_next;
            hold_vld_reg <= hold_vld_next;
            used_reg     <= used_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

    assign result_valid = out_vld_reg;
    assign result       = out_reg;

    // read and write port never hit the same slot in one cycle
    `TTT_NEVER(a_no_rw_same_slot, wr_en && rd_en && (wr_addr == rd_addr), "slot read during its write")
    // a dispatch never releases more runs than allowed
    `TTT_NEVER(a_run_cap, run_cnt_reg > RUN_LIM, "run count beyond limit")
    // add and delete answer in the next cycle with a single final result
    `TTT_ASSERT(a_single_result, accept && (cmd.opcode == OP_ADD || cmd.opcode == OP_DEL) |=> result_valid && result.last, "add or delete result missing")
    // a result that is not final is followed by more work of the same walk
    `TTT_ASSERT(a_more_follows, result_valid && !result.last |-> busy, "non-final result outside walk")
    // the read data stage only runs inside a walk
    `TTT_ASSERT(a_stage_in_walk, p_vld_reg |-> state_reg == S_WALK, "read stage active while idle")

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the time triggered task table: directed cases, then random traffic.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tttt_pkg::*;

    localparam int SLOTS       = SLOT_COUNT_DEF;
    // Longest stretch with no transaction and no result strobe before we call it hung.
    // Worst legal stretch is a sender gap plus one slot walk.
    localparam int STALL_LIMIT = 400;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    in_t  cmd   = '0;
    logic result_valid;
    out_t result;

    time_triggered_task_table dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow copy of the slot table, updated when each command transaction
    // is taken. Every taken command pushes the results it must cause.
    // ------------------------------------------------------------------
    logic        occ       [SLOTS];
    logic [15:0] tsk_id    [SLOTS];
    logic [15:0] countdown [SLOTS];
    logic [15:0] reload    [SLOTS];
    logic [7:0]  runs_owed [SLOTS];

    out_t responses_due[$];
    int   mismatches   = 0;
    int   sent_in_burst = 0;

    function automatic out_t make_resp(status_t st, int sl, logic [15:0] tn, logic fin);
        out_t r;
        r.status          = st;
        r.slot            = sl[7:0];
        r.run_task_number = tn;
        r.last            = fin;
        return r;
    endfunction

    function automatic void clear_entry(int s);
        occ[s]       = 1'b0;
        tsk_id[s]    = '0;
        countdown[s] = '0;
        reload[s]    = '0;
        runs_owed[s] = '0;
    endfunction

    // Works out the results of one command and advances the shadow table.
    task automatic apply_command(in_t c);
        out_t batch [MAX_RUNS];
        int   n;
        int   s;
        n = 0;
        case (c.opcode)
            OP_ADD:
            begin
                s = 0;
                while (s < SLOTS && occ[s])
                    s++;
                if (s == SLOTS)
                    responses_due.push_back(make_resp(ST_FULL, 0, '0, 1'b1));
                else
                begin
                    occ[s]       = 1'b1;
                    tsk_id[s]    = c.task_number;
                    countdown[s] = c.start_delay;
                    reload[s]    = c.repeat_period;
                    runs_owed[s] = '0;
                    responses_due.push_back(make_resp(ST_ADDED, s, '0, 1'b1));
                end
            end
            OP_DEL:
            begin
                if (c.slot_to_delete < SLOTS)
                    clear_entry(c.slot_to_delete);
                responses_due.push_back(make_resp(ST_DELETED, c.slot_to_delete, '0, 1'b1));
            end
            OP_TICK:
            begin
                for (int k = 0; k < SLOTS; k++)
                begin
                    if (occ[k])
                    begin
                        if (countdown[k] == 0)
                        begin
                            if (runs_owed[k] != PEND_MAX)
                                runs_owed[k]++;
                            if (reload[k] != 0)
                                countdown[k] = reload[k];
                        end
                        else
                            countdown[k]--;
                    end
                end
                responses_due.push_back(make_resp(ST_TICKED, 0, '0, 1'b1));
            end
            default:
            begin
                // dispatch: one run per owed slot in slot order, one-shots retired
                for (int k = 0; k < SLOTS && n < MAX_RUNS; k++)
                begin
                    if (occ[k] && runs_owed[k] != 0)
                    begin
                        batch[n] = make_resp(ST_RUN, k, tsk_id[k], 1'b0);
                        n++;
                        runs_owed[k]--;
                        if (reload[k] == 0)
                            clear_entry(k);
                    end
                end
                if (n == 0)
                    responses_due.push_back(make_resp(ST_NONE, 0, '0, 1'b1));
                else
                begin
                    batch[n-1].last = 1'b1;
                    for (int k = 0; k < n; k++)
                        responses_due.push_back(batch[k]);
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Command side. Called right after a rising edge. Commands go out in
    // bursts; between bursts start drops for a random number of cycles,
    // so gaps land on every phase of a slot walk. A quarter of the bursts
    // follow on with no gap at all.
    // ------------------------------------------------------------------
    task automatic send_cmd(in_t c);
        int gap;
        if (sent_in_burst == 0)
        begin
            gap           = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            sent_in_burst = $urandom_range(1, 16);
            if (gap != 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        sent_in_burst--;
        start <= 1'b1;
        cmd   <= c;
        // busy read here is its value before this edge: the transaction is
        // taken on the first edge that sees it low
        do
            @(posedge clk);
        while (busy !== 1'b0);
        apply_command(c);
    endtask

    // Unused fields carry random noise on every command.
    function automatic in_t noise_cmd(op_t op);
        in_t c;
        c.opcode         = op;
        c.task_number    = 16'($urandom_range(0, 65535));
        c.start_delay    = 16'($urandom_range(0, 65535));
        c.repeat_period  = 16'($urandom_range(0, 65535));
        c.slot_to_delete = 8'($urandom_range(0, 255));
        return c;
    endfunction

    task automatic add_task(logic [15:0] tn, logic [15:0] dly, logic [15:0] per);
        in_t c;
        c               = noise_cmd(OP_ADD);
        c.task_number   = tn;
        c.start_delay   = dly;
        c.repeat_period = per;
        send_cmd(c);
    endtask

    task automatic delete_slot(logic [7:0] idx);
        in_t c;
        c                = noise_cmd(OP_DEL);
        c.slot_to_delete = idx;
        send_cmd(c);
    endtask

    task automatic tick();
        send_cmd(noise_cmd(OP_TICK));
    endtask

    task automatic dispatch();
        send_cmd(noise_cmd(OP_DISP));
    endtask

    // ------------------------------------------------------------------
    // Result side: every strobe is a completed transaction and must match
    // the oldest awaited result, field by field.
    // ------------------------------------------------------------------
    task automatic compare_field(string what, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    out_t head_resp;

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (responses_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual status %0d slot %0d",
                         $time, result.status, result.slot);
            end
            else
            begin
                head_resp = responses_due.pop_front();
                compare_field("status", 16'(head_resp.status), 16'(result.status));
                compare_field("slot", 16'(head_resp.slot), 16'(result.slot));
                compare_field("run_task_number", head_resp.run_task_number,
                              result.run_task_number);
                compare_field("last", 16'(head_resp.last), 16'(result.last));
            end
        end
    end

    // Watchdog: cycles with neither a command taken nor a result strobe.
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Fill every slot with due-now tasks (mixed one-shot and periodic,
    // extreme task numbers including zero), then one add too many.
    task automatic test_fill_table();
        add_task(16'h0000, 16'h0000, 16'h0000);
        add_task(16'hFFFF, 16'h0000, 16'h0001);
        add_task(16'h5555, 16'h0000, 16'h0000);
        add_task(16'hAAAA, 16'h0000, 16'hFFFF);
        add_task(16'h0001, 16'h0000, 16'h0000);
        add_task(16'h8000, 16'h0000, 16'h0002);
        add_task(16'h7FFF, 16'h0000, 16'h0000);
        add_task(16'h1234, 16'h0000, 16'h8000);
        add_task(16'hBEEF, 16'h0003, 16'h0003);
    endtask

    // Nothing owed yet, then all eight slots due at once: the longest
    // dispatch, with last on the eighth run and the one-shots retired.
    task automatic test_full_dispatch();
        dispatch();
        tick();
        dispatch();
        tick();
        tick();
        dispatch();
    endtask

    // In-range and out-of-range deletes; adds then land in the lowest
    // free slot, the first with the widest delay and period.
    task automatic test_delete_and_refill();
        delete_slot(8'd1);
        delete_slot(8'(SLOTS));
        delete_slot(8'hFF);
        add_task(16'h0000, 16'hFFFF, 16'hFFFF);
        add_task(16'hFFFF, 16'h0000, 16'h0000);
        delete_slot(8'(SLOTS - 1));
        delete_slot(8'h00);
        tick();
        dispatch();
    endtask

    // A due one-shot ticked several times owes several runs, yet one
    // dispatch runs it once and retires it; the rest of its runs are dropped.
    task automatic test_one_shot_owed();
        for (int s = 0; s < SLOTS; s++)
            delete_slot(8'(s));
        add_task(16'hC0DE, 16'h0000, 16'h0000);
        repeat (5) tick();
        dispatch();
        dispatch();
    endtask

    // Mixed traffic, mostly short delays and periods so tasks come due
    // often; some full-range values and out-of-range deletes as noise.
    task automatic test_random_traffic();
        in_t c;
        int  pick;
        repeat (130)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 24)
            begin
                c = noise_cmd(OP_ADD);
                if ($urandom_range(0, 6) != 0)
                    c.start_delay = 16'($urandom_range(0, 4));
                pick = $urandom_range(0, 19);
                if (pick < 6)
                    c.repeat_period = '0;
                else if (pick < 17)
                    c.repeat_period = 16'($urandom_range(1, 4));
            end
            else if (pick < 38)
            begin
                c = noise_cmd(OP_DEL);
                if ($urandom_range(0, 6) != 0)
                    c.slot_to_delete = 8'($urandom_range(0, SLOTS - 1));
            end
            else if (pick < 72)
                c = noise_cmd(OP_TICK);
            else
                c = noise_cmd(OP_DISP);
            send_cmd(c);
        end
    endtask

    initial
    begin
        for (int s = 0; s < SLOTS; s++)
            clear_entry(s);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_table();
        test_full_dispatch();
        test_delete_and_refill();
        test_one_shot_owed();
        test_random_traffic();

        start <= 1'b0;
        while (responses_due.size() != 0)
            @(posedge clk);
        // let any stray strobe from a walk show up before the verdict
        repeat (SLOTS + 12) @(posedge clk);

        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
